// ----- sv/i2c_master_bit_sequencer_macros.svh -----
// ----------------------------------------------------------------------------
// I2C bit sequencer assertion macros
// Shared assertion forms for the checker of the I2C bit sequencer.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_MACROS_SVH

// Implication in the same cycle, switched off while reset is high.
`define I2CBS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication into the next cycle, switched off while reset is high.
`define I2CBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Implication into the next cycle that also holds across reset.
`define I2CBS_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/i2cbs_pkg.sv -----
// ----------------------------------------------------------------------------
// I2C bit sequencer package
// Command codes, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

   localparam logic [2:0] MODE_START = 3'd0;
   localparam logic [2:0] MODE_STOP  = 3'd1;
   localparam logic [2:0] MODE_WRITE = 3'd2;
   localparam logic [2:0] MODE_READ  = 3'd3;
   localparam logic [2:0] MODE_WAIT  = 3'd4;

   localparam logic [1:0] CSR_SHORT_HOLD = 2'd0;
   localparam logic [1:0] CSR_LONG_HOLD  = 2'd1;
   localparam logic [1:0] CSR_WAIT_LIMIT = 2'd2;

   localparam logic [7:0] SHORT_HOLD_RESET = 8'd1;
   localparam logic [7:0] LONG_HOLD_RESET  = 8'd10;
   localparam logic [7:0] WAIT_LIMIT_RESET = 8'd100;

   localparam logic [7:0] POLLS_NEVER = 8'hFF;
   localparam logic [7:0] HOLD_NONE   = 8'd0;

   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      CMD_START,
      CMD_STOP,
      CMD_WRITE,
      CMD_READ,
      CMD_WAIT
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic         send_ack;
      logic         timeout;
   } cmd_type;

   typedef enum logic [1:0] {
      SEG_IDLE,
      SEG_HEAD,
      SEG_BITS,
      SEG_TAIL
   } seg_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic [7:0] hold_time;
      logic [7:0] read_byte;
      logic       status;
      logic       last;
   } rsp_type;

endpackage

// ----- sv/i2cbs_fifo.sv -----
// ----------------------------------------------------------------------------
// I2C bit sequencer queue
// Small first-in first-out queue in flip-flops with full and empty flags.
// ----------------------------------------------------------------------------
module i2cbs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/i2cbs_front.sv -----
// ----------------------------------------------------------------------------
// I2C bit sequencer front end
// Accepts commands, decodes the mode, settles the acknowledge timeout and
// queues a compact command for the phase engine.
// ----------------------------------------------------------------------------
module i2cbs_front #(
   parameter int CMD_DEPTH = i2cbs_pkg::CMD_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [2:0]          req_mode,
   input  logic [7:0]          req_write_data,
   input  logic                req_send_ack,
   input  logic [7:0]          req_slave_bits,
   input  logic [7:0]          req_ack_wait_polls,
   input  logic [7:0]          wait_limit,
   output logic                cmd_valid,
   output i2cbs_pkg::cmd_type  cmd,
   input  logic                cmd_take
);

   localparam int CMD_W = $bits(i2cbs_pkg::cmd_type);

   i2cbs_pkg::cmd_type cmd_new;
   logic               mode_ok;
   logic [CMD_W-1:0]   queue_out;
   logic               queue_empty;

   always_comb begin
      mode_ok      = 1'b1;
      cmd_new.kind = i2cbs_pkg::CMD_START;
      unique case (req_mode)
         i2cbs_pkg::MODE_START: cmd_new.kind = i2cbs_pkg::CMD_START;
         i2cbs_pkg::MODE_STOP:  cmd_new.kind = i2cbs_pkg::CMD_STOP;
         i2cbs_pkg::MODE_WRITE: cmd_new.kind = i2cbs_pkg::CMD_WRITE;
         i2cbs_pkg::MODE_READ:  cmd_new.kind = i2cbs_pkg::CMD_READ;
         i2cbs_pkg::MODE_WAIT:  cmd_new.kind = i2cbs_pkg::CMD_WAIT;
         default:               mode_ok      = 1'b0;
      endcase
      cmd_new.data     = (req_mode == i2cbs_pkg::MODE_WRITE) ? req_write_data
                                                              : req_slave_bits;
      cmd_new.send_ack = req_send_ack;
      cmd_new.timeout  = (req_ack_wait_polls == i2cbs_pkg::POLLS_NEVER)
                         || (req_ack_wait_polls > wait_limit);
   end

   i2cbs_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && mode_ok),
      .push_data (cmd_new),
      .full      (req_full),
      .pop       (cmd_take),
      .pop_data  (queue_out),
      .empty     (queue_empty)
   );

   assign cmd_valid = !queue_empty;
   assign cmd       = i2cbs_pkg::cmd_type'(queue_out);

endmodule

// ----- sv/i2cbs_back.sv -----
// ----------------------------------------------------------------------------
// I2C bit sequencer phase engine
// Steps through the pin phases of a command, one per cycle when the result
// queue has room, tracks the SCL and SDA levels and hands each phase to it.
// ----------------------------------------------------------------------------
module i2cbs_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  i2cbs_pkg::cmd_type cmd,
   output logic               cmd_take,
   input  logic [7:0]         short_hold,
   input  logic [7:0]         long_hold,
   input  logic               rsp_full,
   output logic               rsp_push,
   output i2cbs_pkg::rsp_type rsp
);

   i2cbs_pkg::seg_type seg_ff, seg_in, seg_nxt;
   i2cbs_pkg::cmd_type cmd_ff, cmd_in;
   logic [1:0]         sub_ff, sub_in, sub_nxt;
   logic [2:0]         bit_ff, bit_in, bit_nxt;
   logic [7:0]         byte_ff, byte_in, byte_nxt;
   logic               clk_line_ff, clk_line_in;
   logic               data_line_ff, data_line_in;
   logic               emit;

   always_comb begin
      rsp.scl_level = clk_line_ff;
      rsp.sda_level = data_line_ff;
      rsp.hold_time = i2cbs_pkg::HOLD_NONE;
      rsp.read_byte = 8'd0;
      rsp.status    = 1'b0;
      rsp.last      = 1'b0;
      seg_nxt       = seg_ff;
      sub_nxt       = sub_ff + 1'b1;
      bit_nxt       = bit_ff;
      byte_nxt      = byte_ff;

      if (seg_ff != i2cbs_pkg::SEG_IDLE) begin
         unique case (cmd_ff.kind)
            i2cbs_pkg::CMD_START: begin
               case (sub_ff)
                  2'd0: begin
                     rsp.sda_level = 1'b1;
                     rsp.hold_time = short_hold;
                  end
                  2'd1: begin
                     rsp.scl_level = 1'b1;
                     rsp.sda_level = 1'b1;
                     rsp.hold_time = short_hold;
                  end
                  2'd2: begin
                     rsp.scl_level = 1'b1;
                     rsp.sda_level = 1'b0;
                     rsp.hold_time = short_hold;
                  end
                  default: begin
                     rsp.scl_level = 1'b0;
                     rsp.sda_level = 1'b0;
                     rsp.last      = 1'b1;
                  end
               endcase
            end
            i2cbs_pkg::CMD_STOP: begin
               case (sub_ff)
                  2'd0: begin
                     rsp.sda_level = 1'b0;
                     rsp.hold_time = short_hold;
                  end
                  2'd1: begin
                     rsp.scl_level = 1'b1;
                     rsp.sda_level = 1'b0;
                     rsp.hold_time = short_hold;
                  end
                  default: begin
                     rsp.scl_level = 1'b1;
                     rsp.sda_level = 1'b1;
                     rsp.last      = 1'b1;
                  end
               endcase
            end
            i2cbs_pkg::CMD_WAIT: begin
               case (sub_ff)
                  2'd0: begin
                     rsp.scl_level = 1'b1;
                     rsp.sda_level = 1'b1;
                     rsp.hold_time = short_hold;
                  end
                  2'd1: begin
                     if (cmd_ff.timeout) begin
                        rsp.scl_level = 1'b1;
                        rsp.sda_level = 1'b0;
                        rsp.hold_time = short_hold;
                     end else begin
                        rsp.scl_level = 1'b0;
                        rsp.sda_level = 1'b1;
                        rsp.last      = 1'b1;
                     end
                  end
                  2'd2: begin
                     rsp.scl_level = 1'b1;
                     rsp.sda_level = 1'b0;
                     rsp.hold_time = short_hold;
                  end
                  default: begin
                     rsp.scl_level = 1'b1;
                     rsp.sda_level = 1'b1;
                     rsp.status    = 1'b1;
                     rsp.last      = 1'b1;
                  end
               endcase
            end
            i2cbs_pkg::CMD_WRITE: begin
               if (seg_ff == i2cbs_pkg::SEG_HEAD) begin
                  rsp.scl_level = 1'b0;
                  seg_nxt       = i2cbs_pkg::SEG_BITS;
                  sub_nxt       = 2'd0;
                  bit_nxt       = 3'd0;
               end else begin
                  rsp.scl_level = (sub_ff == 2'd1);
                  rsp.sda_level = byte_ff[7];
                  rsp.hold_time = long_hold;
                  if (sub_ff == 2'd2) begin
                     rsp.last = (bit_ff == 3'd7);
                     sub_nxt  = 2'd0;
                     bit_nxt  = bit_ff + 1'b1;
                     byte_nxt = {byte_ff[6:0], 1'b0};
                  end
               end
            end
            i2cbs_pkg::CMD_READ: begin
               if (seg_ff == i2cbs_pkg::SEG_BITS) begin
                  rsp.sda_level = 1'b1;
                  if (sub_ff == 2'd0) begin
                     rsp.scl_level = 1'b0;
                     rsp.hold_time = short_hold;
                  end else begin
                     rsp.scl_level = 1'b1;
                     sub_nxt       = 2'd0;
                     bit_nxt       = bit_ff + 1'b1;
                     if (bit_ff == 3'd7) begin
                        seg_nxt = i2cbs_pkg::SEG_TAIL;
                     end
                  end
               end else begin
                  case (sub_ff)
                     2'd0: begin
                        rsp.scl_level = 1'b0;
                     end
                     2'd1: begin
                        rsp.scl_level = 1'b0;
                        rsp.sda_level = !cmd_ff.send_ack;
                        rsp.hold_time = short_hold;
                     end
                     2'd2: begin
                        rsp.scl_level = 1'b1;
                        rsp.hold_time = short_hold;
                     end
                     default: begin
                        rsp.scl_level = 1'b0;
                        rsp.read_byte = cmd_ff.data;
                        rsp.last      = 1'b1;
                     end
                  endcase
               end
            end
            default: begin
               rsp.last = 1'b1;
            end
         endcase
      end
   end

   assign emit     = (seg_ff != i2cbs_pkg::SEG_IDLE) && !rsp_full;
   assign rsp_push = emit;
   assign cmd_take = cmd_valid && ((seg_ff == i2cbs_pkg::SEG_IDLE) || (emit && rsp.last));

   always_comb begin
      seg_in       = seg_ff;
      sub_in       = sub_ff;
      bit_in       = bit_ff;
      byte_in      = byte_ff;
      cmd_in       = cmd_ff;
      clk_line_in  = clk_line_ff;
      data_line_in = data_line_ff;
      if (emit) begin
         clk_line_in  = rsp.scl_level;
         data_line_in = rsp.sda_level;
         seg_in       = rsp.last ? i2cbs_pkg::SEG_IDLE : seg_nxt;
         sub_in       = sub_nxt;
         bit_in       = bit_nxt;
         byte_in      = byte_nxt;
      end
      if (cmd_take) begin
         cmd_in  = cmd;
         byte_in = cmd.data;
         sub_in  = 2'd0;
         bit_in  = 3'd0;
         seg_in  = (cmd.kind == i2cbs_pkg::CMD_READ) ? i2cbs_pkg::SEG_BITS
                                                     : i2cbs_pkg::SEG_HEAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= i2cbs_pkg::SEG_IDLE;
         sub_ff       <= 2'd0;
         bit_ff       <= 3'd0;
         clk_line_ff  <= 1'b1;
         data_line_ff <= 1'b1;
      end else begin
         seg_ff       <= seg_in;
         sub_ff       <= sub_in;
         bit_ff       <= bit_in;
         clk_line_ff  <= clk_line_in;
         data_line_ff <= data_line_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      byte_ff <= byte_in;
   end

endmodule

// ----- sv/i2c_master_bit_sequencer.sv -----
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Turns I2C master commands into the run of SCL/SDA pin settings, each with
// its hold time in 10 us units.
//
// Commands are pushed on the req_ channel (push/full) and the pin phases are
// taken from the rsp_ channel (empty/pop); rsp_last marks the final phase of a
// command, which also carries the read byte and the timeout status. Modes five
// to seven are taken and produce nothing.
// The front end queues decoded commands, so a new command is taken while the
// phase engine still works on earlier ones. While the result queue has room,
// the engine produces one phase per cycle: start 4, stop 3, write 25, read 20,
// wait 2 or 4 phases. The first phase of a command passes the command queue,
// the engine registers and the result queue before it can be popped; commands
// follow each other with no gap, so each command's phase count sets the rate.
// When the consumer stalls, the result queue fills, the engine holds its place
// and the command queue in turn raises full. Synchronous reset empties both
// queues, marks both bus lines high and loads the hold and wait limit
// registers with their defaults. The csr_ port writes a register; the user
// must use it only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer #(
   parameter int CMD_DEPTH = i2cbs_pkg::CMD_QUEUE_DEPTH,
   parameter int RSP_DEPTH = i2cbs_pkg::RSP_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_write_data,
   input  logic       req_send_ack,
   input  logic [7:0] req_slave_bits,
   input  logic [7:0] req_ack_wait_polls,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_scl_level,
   output logic       rsp_sda_level,
   output logic [7:0] rsp_hold_time,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_status,
   output logic       rsp_last,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   localparam int RSP_W = $bits(i2cbs_pkg::rsp_type);

   logic [7:0]         short_hold_ff, short_hold_in;
   logic [7:0]         long_hold_ff, long_hold_in;
   logic [7:0]         wait_limit_ff, wait_limit_in;
   logic               cmd_valid;
   logic               cmd_take;
   i2cbs_pkg::cmd_type cmd;
   logic               rsp_full;
   logic               rsp_push;
   i2cbs_pkg::rsp_type rsp_new;
   logic [RSP_W-1:0]   rsp_queue_out;
   i2cbs_pkg::rsp_type rsp_head;

   always_comb begin
      short_hold_in = short_hold_ff;
      long_hold_in  = long_hold_ff;
      wait_limit_in = wait_limit_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            i2cbs_pkg::CSR_SHORT_HOLD: short_hold_in = csr_data;
            i2cbs_pkg::CSR_LONG_HOLD:  long_hold_in  = csr_data;
            i2cbs_pkg::CSR_WAIT_LIMIT: wait_limit_in = csr_data;
            default:                   wait_limit_in = wait_limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_hold_ff <= i2cbs_pkg::SHORT_HOLD_RESET;
         long_hold_ff  <= i2cbs_pkg::LONG_HOLD_RESET;
         wait_limit_ff <= i2cbs_pkg::WAIT_LIMIT_RESET;
      end else begin
         short_hold_ff <= short_hold_in;
         long_hold_ff  <= long_hold_in;
         wait_limit_ff <= wait_limit_in;
      end
   end

   i2cbs_front #(
      .CMD_DEPTH (CMD_DEPTH)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_mode           (req_mode),
      .req_write_data     (req_write_data),
      .req_send_ack       (req_send_ack),
      .req_slave_bits     (req_slave_bits),
      .req_ack_wait_polls (req_ack_wait_polls),
      .wait_limit         (wait_limit_ff),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_take           (cmd_take)
   );

   i2cbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_take   (cmd_take),
      .short_hold (short_hold_ff),
      .long_hold  (long_hold_ff),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp        (rsp_new)
   );

   i2cbs_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_queue_out),
      .empty     (rsp_empty)
   );

   assign rsp_head      = i2cbs_pkg::rsp_type'(rsp_queue_out);
   assign rsp_scl_level = rsp_head.scl_level;
   assign rsp_sda_level = rsp_head.sda_level;
   assign rsp_hold_time = rsp_head.hold_time;
   assign rsp_read_byte = rsp_head.read_byte;
   assign rsp_status    = rsp_head.status;
   assign rsp_last      = rsp_head.last;

endmodule

// ----- sv/i2cbs_checker.sv -----
// ----------------------------------------------------------------------------
// I2C bit sequencer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_sequencer_macros.svh"

module i2cbs_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_scl_level,
   input logic       rsp_sda_level,
   input logic [7:0] rsp_hold_time,
   input logic [7:0] rsp_read_byte,
   input logic       rsp_status,
   input logic       rsp_last
);

   logic        rsp_shown;
   logic        stalled;
   logic        stop_closed;
   logic [19:0] rsp_word;

   assign rsp_shown   = !rsp_empty;
   assign stalled     = rsp_shown && !rsp_pop;
   assign stop_closed = rsp_last && rsp_scl_level && rsp_sda_level;
   assign rsp_word    = {rsp_scl_level, rsp_sda_level, rsp_hold_time, rsp_read_byte,
                         rsp_status, rsp_last};

   // A reset leaves no result waiting.
   `I2CBS_ASSERT_NEXT_ALWAYS(a_reset_empties, reset, rsp_empty, "results left after reset")

   // A timeout ends its command with a stop, leaving both lines high.
   `I2CBS_ASSERT_IMPLY(a_timeout_stop, rsp_shown && rsp_status, stop_closed, "timeout without stop")

   // The read byte is carried only by the final phase of a command.
   `I2CBS_ASSERT_IMPLY(a_byte_on_last, rsp_shown && |rsp_read_byte, rsp_last, "early read byte")

   // A waiting result that is not taken stays in place.
   `I2CBS_ASSERT_NEXT(a_stall_holds, stalled, rsp_shown && $stable(rsp_word), "stalled result changed")

endmodule

bind i2c_master_bit_sequencer i2cbs_checker u_checker (.*);

// ----- sim/i2c_master_bit_sequencer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Drives commands into the sequencer with bursty traffic and a receiver that
// stalls in several patterns, and predicts every pin phase from its own model
// of the bus lines and hold registers. Each accepted phase is checked against
// the oldest prediction. The run steps through several register settings,
// including both extremes, and forces the block to fill up at least once.
// ----------------------------------------------------------------------------
class i2c_phase_scoreboard;

   i2cbs_pkg::rsp_type expected_q[$];
   logic [7:0]         short_hold;
   logic [7:0]         long_hold;
   logic [7:0]         wait_limit;
   logic               scl_now;
   logic               sda_now;
   int                 mismatches;
   int                 phases_checked;
   int                 commands_noted;
   int                 reads_noted;
   int                 writes_noted;
   int                 timeouts_noted;
   int                 ignored_noted;

   function new();
      short_hold = i2cbs_pkg::SHORT_HOLD_RESET;
      long_hold  = i2cbs_pkg::LONG_HOLD_RESET;
      wait_limit = i2cbs_pkg::WAIT_LIMIT_RESET;
      scl_now    = 1'b1;
      sda_now    = 1'b1;
   endfunction

   function void set_reg(logic [1:0] index, logic [7:0] value);
      case (index)
         i2cbs_pkg::CSR_SHORT_HOLD: short_hold = value;
         i2cbs_pkg::CSR_LONG_HOLD:  long_hold  = value;
         i2cbs_pkg::CSR_WAIT_LIMIT: wait_limit = value;
         default: ;
      endcase
   endfunction

   function void add_phase(logic scl, logic sda, logic [7:0] hold);
      i2cbs_pkg::rsp_type ph;
      scl_now      = scl;
      sda_now      = sda;
      ph.scl_level = scl;
      ph.sda_level = sda;
      ph.hold_time = hold;
      ph.read_byte = 8'h00;
      ph.status    = 1'b0;
      ph.last      = 1'b0;
      expected_q.push_back(ph);
   endfunction

   function void finish_command(logic [7:0] rbyte, logic st);
      expected_q[$].read_byte = rbyte;
      expected_q[$].status    = st;
      expected_q[$].last      = 1'b1;
   endfunction

   function void stop_phases();
      add_phase(scl_now, 1'b0, short_hold);
      add_phase(1'b1, 1'b0, short_hold);
      add_phase(1'b1, 1'b1, i2cbs_pkg::HOLD_NONE);
   endfunction

   function void note_command(logic [2:0] mode, logic [7:0] wdata, logic ack,
                              logic [7:0] sbits, logic [7:0] polls);
      commands_noted++;
      case (mode)
         i2cbs_pkg::MODE_START: begin
            add_phase(scl_now, 1'b1, short_hold);
            add_phase(1'b1, 1'b1, short_hold);
            add_phase(1'b1, 1'b0, short_hold);
            add_phase(1'b0, 1'b0, i2cbs_pkg::HOLD_NONE);
            finish_command(8'h00, 1'b0);
         end
         i2cbs_pkg::MODE_STOP: begin
            stop_phases();
            finish_command(8'h00, 1'b0);
         end
         i2cbs_pkg::MODE_WRITE: begin
            writes_noted++;
            add_phase(1'b0, sda_now, i2cbs_pkg::HOLD_NONE);
            for (int b = 7; b >= 0; b--) begin
               add_phase(1'b0, wdata[b], long_hold);
               add_phase(1'b1, wdata[b], long_hold);
               add_phase(1'b0, wdata[b], long_hold);
            end
            finish_command(8'h00, 1'b0);
         end
         i2cbs_pkg::MODE_READ: begin
            reads_noted++;
            for (int b = 7; b >= 0; b--) begin
               add_phase(1'b0, 1'b1, short_hold);
               add_phase(1'b1, 1'b1, i2cbs_pkg::HOLD_NONE);
            end
            add_phase(1'b0, sda_now, i2cbs_pkg::HOLD_NONE);
            add_phase(1'b0, ~ack, short_hold);
            add_phase(1'b1, sda_now, short_hold);
            add_phase(1'b0, sda_now, i2cbs_pkg::HOLD_NONE);
            finish_command(sbits, 1'b0);
         end
         i2cbs_pkg::MODE_WAIT: begin
            add_phase(1'b1, 1'b1, short_hold);
            if (polls == i2cbs_pkg::POLLS_NEVER || polls > wait_limit) begin
               timeouts_noted++;
               stop_phases();
               finish_command(8'h00, 1'b1);
            end else begin
               add_phase(1'b0, sda_now, i2cbs_pkg::HOLD_NONE);
               finish_command(8'h00, 1'b0);
            end
         end
         default: ignored_noted++;
      endcase
   endfunction

   function void check_phase(i2cbs_pkg::rsp_type got);
      i2cbs_pkg::rsp_type want;
      phases_checked++;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"Unexpected pin phase: scl=%b sda=%b hold=%0d byte=%h ",
                      "status=%b last=%b"},
                     got.scl_level, got.sda_level, got.hold_time, got.read_byte,
                     got.status, got.last);
         return;
      end
      want = expected_q.pop_front();
      if (got.scl_level !== want.scl_level || got.sda_level !== want.sda_level ||
          got.hold_time !== want.hold_time || got.read_byte !== want.read_byte ||
          got.status !== want.status || got.last !== want.last) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"Phase %0d mismatch: expected scl=%b sda=%b hold=%0d byte=%h ",
                      "status=%b last=%b, got scl=%b sda=%b hold=%0d byte=%h ",
                      "status=%b last=%b"},
                     phases_checked, want.scl_level, want.sda_level, want.hold_time,
                     want.read_byte, want.status, want.last, got.scl_level,
                     got.sda_level, got.hold_time, got.read_byte, got.status, got.last);
      end
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

endclass

module i2c_master_bit_sequencer_tb;

   localparam int RUN_LIMIT     = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_OFF_LEN  = 300;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] wdata;
      logic       ack;
      logic [7:0] sbits;
      logic [7:0] polls;
   } cmd_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [2:0] req_mode = '0;
   logic [7:0] req_write_data = '0;
   logic       req_send_ack = 1'b0;
   logic [7:0] req_slave_bits = '0;
   logic [7:0] req_ack_wait_polls = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_scl_level;
   logic       rsp_sda_level;
   logic [7:0] rsp_hold_time;
   logic [7:0] rsp_read_byte;
   logic       rsp_status;
   logic       rsp_last;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   i2c_phase_scoreboard sb = new();
   i2cbs_pkg::rsp_type  rsp_seen;
   int                  cycle_count = 0;
   int                  burst_left = 0;
   int                  real_items = 0;
   int                  settings_used = 0;
   int                  hold_off_asked = 0;
   int                  hold_off_done = 0;

   i2c_master_bit_sequencer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_mode           (req_mode),
      .req_write_data     (req_write_data),
      .req_send_ack       (req_send_ack),
      .req_slave_bits     (req_slave_bits),
      .req_ack_wait_polls (req_ack_wait_polls),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_scl_level      (rsp_scl_level),
      .rsp_sda_level      (rsp_sda_level),
      .rsp_hold_time      (rsp_hold_time),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("Run stopped by the cycle limit with %0d phases outstanding.",
                  sb.pending());
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en)
            sb.set_reg(csr_index, csr_data);
         if (req_push && !req_full)
            sb.note_command(req_mode, req_write_data, req_send_ack, req_slave_bits,
                            req_ack_wait_polls);
         if (rsp_pop && !rsp_empty) begin
            rsp_seen = '{rsp_scl_level, rsp_sda_level, rsp_hold_time, rsp_read_byte,
                         rsp_status, rsp_last};
            sb.check_phase(rsp_seen);
         end
      end
   end

   initial begin
      int style;
      int span;
      int hold_left;
      hold_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         style = $urandom_range(0, 3);
         span  = $urandom_range(20, 150);
         for (int k = 0; k < span; k++) begin
            @(posedge clock);
            if (hold_off_asked != hold_off_done) begin
               hold_off_done++;
               hold_left = HOLD_OFF_LEN;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_pop <= 1'b0;
            end else begin
               case (style)
                  0: rsp_pop <= 1'b1;
                  1: rsp_pop <= 1'($urandom_range(0, 1));
                  2: rsp_pop <= ($urandom_range(0, 7) != 0);
                  default: rsp_pop <= (k % 4 == 0);
               endcase
            end
         end
      end
   end

   function automatic logic [7:0] rand_polls();
      case ($urandom_range(0, 5))
         0: return i2cbs_pkg::POLLS_NEVER;
         1: return sb.wait_limit;
         2: return sb.wait_limit + 8'd1;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic cmd_item_type random_cmd(logic [2:0] mode);
      cmd_item_type it;
      it.mode  = mode;
      it.wdata = 8'($urandom_range(0, 255));
      it.ack   = 1'($urandom_range(0, 1));
      it.sbits = 8'($urandom_range(0, 255));
      it.polls = rand_polls();
      return it;
   endfunction

   function automatic cmd_item_type cmd(logic [2:0] mode, logic [7:0] wdata, logic ack,
                                        logic [7:0] sbits, logic [7:0] polls);
      return '{mode, wdata, ack, sbits, polls};
   endfunction

   task automatic send_item(input cmd_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap != 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      if (it.mode <= i2cbs_pkg::MODE_WAIT)
         real_items++;
      req_push           <= 1'b1;
      req_mode           <= it.mode;
      req_write_data     <= it.wdata;
      req_send_ack       <= it.ack;
      req_slave_bits     <= it.sbits;
      req_ack_wait_polls <= it.polls;
      do @(posedge clock); while (req_full);
   endtask

   task automatic drain_block();
      req_push <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input logic [7:0] sh, input logic [7:0] lh,
                                input logic [7:0] wl);
      logic [1:0] idx [3];
      logic [7:0] val [3];
      idx = '{i2cbs_pkg::CSR_SHORT_HOLD, i2cbs_pkg::CSR_LONG_HOLD,
              i2cbs_pkg::CSR_WAIT_LIMIT};
      val = '{sh, lh, wl};
      drain_block();
      for (int k = 0; k < 3; k++) begin
         csr_wr_en <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= val[k];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   task automatic run_traffic(input int target);
      int           first;
      int           nbytes;
      logic         is_read;
      cmd_item_type it;
      first = real_items;
      while (real_items - first < target) begin
         if ($urandom_range(0, 9) < 8) begin
            send_item(random_cmd(i2cbs_pkg::MODE_START));
            it = random_cmd(i2cbs_pkg::MODE_WRITE);
            is_read = it.wdata[0];
            send_item(it);
            send_item(random_cmd(i2cbs_pkg::MODE_WAIT));
            nbytes = $urandom_range(1, 4);
            for (int k = 0; k < nbytes; k++) begin
               if (is_read) begin
                  it = random_cmd(i2cbs_pkg::MODE_READ);
                  it.ack = (k != nbytes - 1);
                  send_item(it);
               end else begin
                  send_item(random_cmd(i2cbs_pkg::MODE_WRITE));
                  send_item(random_cmd(i2cbs_pkg::MODE_WAIT));
               end
            end
            send_item(random_cmd(i2cbs_pkg::MODE_STOP));
         end else begin
            send_item(random_cmd(3'($urandom_range(0, 7))));
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: every command, field extremes, both wait outcomes and
      // the unused codes.
      send_item(cmd(i2cbs_pkg::MODE_START, 8'h00, 1'b0, 8'h00, 8'h00));
      send_item(cmd(i2cbs_pkg::MODE_WRITE, 8'h00, 1'b0, 8'h00, 8'h00));
      send_item(cmd(i2cbs_pkg::MODE_WRITE, 8'hFF, 1'b1, 8'hFF, 8'hFF));
      send_item(cmd(i2cbs_pkg::MODE_WRITE, 8'hA5, 1'b0, 8'h00, 8'h00));
      send_item(cmd(i2cbs_pkg::MODE_WAIT, 8'h00, 1'b0, 8'h00, 8'h00));
      send_item(cmd(i2cbs_pkg::MODE_WAIT, 8'hFF, 1'b1, 8'hFF,
                    i2cbs_pkg::WAIT_LIMIT_RESET));
      send_item(cmd(i2cbs_pkg::MODE_WAIT, 8'h00, 1'b0, 8'h00,
                    i2cbs_pkg::WAIT_LIMIT_RESET + 8'd1));
      send_item(cmd(i2cbs_pkg::MODE_WAIT, 8'h00, 1'b0, 8'h00, i2cbs_pkg::POLLS_NEVER));
      send_item(cmd(i2cbs_pkg::MODE_START, 8'hFF, 1'b1, 8'hFF, 8'hFF));
      send_item(cmd(i2cbs_pkg::MODE_READ, 8'h00, 1'b1, 8'h00, 8'h00));
      send_item(cmd(i2cbs_pkg::MODE_READ, 8'hFF, 1'b0, 8'hFF, 8'hFF));
      send_item(cmd(i2cbs_pkg::MODE_READ, 8'h3C, 1'b1, 8'h5A, 8'h10));
      send_item(cmd(i2cbs_pkg::MODE_STOP, 8'h00, 1'b0, 8'h00, 8'h00));
      send_item(cmd(3'd5, 8'hFF, 1'b1, 8'hFF, 8'hFF));
      send_item(cmd(3'd6, 8'h00, 1'b0, 8'h00, 8'h00));
      send_item(cmd(3'd7, 8'hFF, 1'b1, 8'hFF, 8'hFF));
      send_item(cmd(i2cbs_pkg::MODE_STOP, 8'hFF, 1'b1, 8'hFF, 8'hFF));
      send_item(cmd(i2cbs_pkg::MODE_WRITE, 8'h3C, 1'b0, 8'h00, 8'h00));
      send_item(cmd(i2cbs_pkg::MODE_WAIT, 8'h00, 1'b0, 8'h00, 8'd254));
      run_traffic(40);

      load_settings(8'd0, 8'd0, 8'd0);
      send_item(cmd(i2cbs_pkg::MODE_WAIT, 8'h00, 1'b0, 8'h00, 8'd0));
      send_item(cmd(i2cbs_pkg::MODE_WAIT, 8'h00, 1'b0, 8'h00, 8'd1));
      run_traffic(40);

      load_settings(8'd255, 8'd255, 8'd255);
      send_item(cmd(i2cbs_pkg::MODE_WAIT, 8'h00, 1'b0, 8'h00, 8'd254));
      send_item(cmd(i2cbs_pkg::MODE_WAIT, 8'h00, 1'b0, 8'h00, i2cbs_pkg::POLLS_NEVER));
      // The receiver holds off while a full burst of writes is offered, so
      // both queues fill and the input side refuses transfers for a while.
      hold_off_asked++;
      burst_left = 14;
      repeat (14) send_item(random_cmd(i2cbs_pkg::MODE_WRITE));
      run_traffic(25);

      load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
      run_traffic(40);

      load_settings(i2cbs_pkg::SHORT_HOLD_RESET, i2cbs_pkg::LONG_HOLD_RESET,
                    i2cbs_pkg::WAIT_LIMIT_RESET);
      run_traffic(40);

      load_settings(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                    8'($urandom_range(0, 15)));
      run_traffic(40);

      drain_block();
      $display("Checked %0d pin phases from %0d commands under %0d register settings.",
               sb.phases_checked, sb.commands_noted, settings_used + 1);
      $display({"Commands included %0d writes, %0d reads, %0d acknowledge timeouts ",
                "and %0d unused codes."},
               sb.writes_noted, sb.reads_noted, sb.timeouts_noted, sb.ignored_noted);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
